/* hdl/lmps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lmps_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int POS_W       = 8;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_FILL  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] REG_ROTATION   = 2'd0;
    localparam logic [1:0] REG_SERPENTINE = 2'd1;
    localparam logic [1:0] REG_MIRROR_X   = 2'd2;
    localparam logic [1:0] REG_MIRROR_Y   = 2'd3;

    typedef struct packed {
        logic [1:0] rotation;
        logic       serpentine;
        logic       mirror_x;
        logic       mirror_y;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       mode;
        logic             on_panel;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] crow;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [POS_W-1:0] chain_pos;
    } t_cmd;

    typedef struct packed {
        logic             in_range;
        logic [POS_W-1:0] mapped_pos;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [7:0]       blue;
    } t_res;

endpackage

`default_nettype wire

/* hdl/led_matrix_pixel_store_top.sv */
// write, unused: result from ST_IDLE; read: from ST_READ; fill: ST_FILL then ST_DONE
// one write per cycle while the output is free; a read or fill blocks the next word
// a fill writes all of the 256 entry store through its single write port
// reset: synchronous active low; registers return to rotation 270, serpentine on
// the store needs no clearing pass, per-entry valid bits make it read as black
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_pixel_store_top
    import lmps_pkg::*;
#(
    parameter int WIDTH  = 16,
    parameter int HEIGHT = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,  // pos_x, pos_y, red, green, blue, chain_pos
    input  wire  [1:0]  s_axis_tuser,  // mode

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,  // mapped_pos, out_green, out_red, out_blue
    output logic [0:0]  m_axis_tuser,  // in_range

    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] r_rotation;
    logic       r_serpentine;
    logic       r_mirror_x;
    logic       r_mirror_y;
    logic       w_cfg_we;
    t_cfg       w_cfg;

    logic       w_full;
    logic       w_empty;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd_in;
    t_cmd       w_cmd_out;
    t_res       w_res;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation   <= ROT_270;
            r_serpentine <= 1'b1;
            r_mirror_x   <= 1'b0;
            r_mirror_y   <= 1'b0;
        end else if (w_cfg_we) begin
            unique case (paddr[3:2])
                REG_ROTATION:   r_rotation   <= pwdata[1:0];
                REG_SERPENTINE: r_serpentine <= pwdata[0];
                REG_MIRROR_X:   r_mirror_x   <= pwdata[0];
                REG_MIRROR_Y:   r_mirror_y   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROTATION:   prdata = {30'd0, r_rotation};
            REG_SERPENTINE: prdata = {31'd0, r_serpentine};
            REG_MIRROR_X:   prdata = {31'd0, r_mirror_x};
            REG_MIRROR_Y:   prdata = {31'd0, r_mirror_y};
            default:        prdata = 32'd0;
        endcase
    end

    always_comb begin
        w_cfg.rotation   = r_rotation;
        w_cfg.serpentine = r_serpentine;
        w_cfg.mirror_x   = r_mirror_x;
        w_cfg.mirror_y   = r_mirror_y;
    end

    lmps_front #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_front (
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_mode  (s_axis_tuser),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    lmps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    lmps_back #(
        .WIDTH (WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_res)
    );

    assign m_axis_tdata = {w_res.blue, w_res.red, w_res.green, w_res.mapped_pos};
    assign m_axis_tuser = w_res.in_range;

endmodule

`default_nettype wire

/* hdl/lmps_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmps_front
    import lmps_pkg::*;
#(
    parameter int WIDTH  = 16,
    parameter int HEIGHT = 16
) (
    input  wire t_cfg        i_cfg,
    input  wire              i_valid,
    input  wire logic [63:0] i_data,  // pos_x, pos_y, red, green, blue, chain_pos
    input  wire logic [1:0]  i_mode,
    input  wire              i_full,
    output logic             o_ready,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam logic [16:0] W_LIM = 17'(WIDTH);
    localparam logic [16:0] H_LIM = 17'(HEIGHT);
    localparam logic [8:0]  W_9   = 9'(WIDTH);
    localparam logic [8:0]  H_9   = 9'(HEIGHT);
    localparam logic [POS_W-1:0] W_M1 = POS_W'(WIDTH - 1);
    localparam logic [POS_W-1:0] H_M1 = POS_W'(HEIGHT - 1);

    logic [15:0]      w_x;
    logic [15:0]      w_y;
    logic [POS_W-1:0] w_xs;
    logic [POS_W-1:0] w_ys;
    logic             w_on_xy;
    logic             w_quarter;
    logic [POS_W-1:0] w_col_r;
    logic [POS_W-1:0] w_row_r;
    logic [POS_W-1:0] w_col_m;
    logic [POS_W-1:0] w_row_m;
    logic [POS_W-1:0] w_crow;
    logic [POS_W-1:0] w_col;

    assign w_x  = i_data[15:0];
    assign w_y  = i_data[31:16];
    assign w_xs = w_x[POS_W-1:0];
    assign w_ys = w_y[POS_W-1:0];

    assign w_on_xy   = ({1'b0, w_x} < W_LIM) && ({1'b0, w_y} < H_LIM);
    assign w_quarter = (i_cfg.rotation == ROT_90) || (i_cfg.rotation == ROT_270);

    always_comb begin
        unique case (i_cfg.rotation)
            ROT_90: begin
                w_col_r = H_M1 - w_ys;
                w_row_r = w_xs;
            end
            ROT_180: begin
                w_col_r = W_M1 - w_xs;
                w_row_r = H_M1 - w_ys;
            end
            ROT_270: begin
                w_col_r = w_ys;
                w_row_r = W_M1 - w_xs;
            end
            default: begin
                w_col_r = w_xs;
                w_row_r = w_ys;
            end
        endcase
    end

    assign w_col_m = i_cfg.mirror_x ? ((w_quarter ? H_M1 : W_M1) - w_col_r) : w_col_r;
    assign w_row_m = i_cfg.mirror_y ? ((w_quarter ? W_M1 : H_M1) - w_row_r) : w_row_r;

    // chain row 0 is the bottom panel row
    assign w_crow = H_M1 - w_row_m;
    assign w_col  = (i_cfg.serpentine && w_crow[0]) ? (W_M1 - w_col_m) : w_col_m;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.mode      = i_mode;
        o_cmd.on_panel  = w_on_xy && ({1'b0, w_col_m} < W_9) && ({1'b0, w_row_m} < H_9);
        o_cmd.col       = w_col;
        o_cmd.crow      = w_crow;
        o_cmd.red       = i_data[39:32];
        o_cmd.green     = i_data[47:40];
        o_cmd.blue      = i_data[55:48];
        o_cmd.chain_pos = i_data[63:56];
    end

endmodule

`default_nettype wire

/* hdl/lmps_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmps_fifo
    import lmps_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  wire t_cmd  i_cmd,
    input  wire        i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_cmd       o_cmd
);

    localparam logic [QPTR_W:0] CNT_FULL = (QPTR_W + 1)'(QDEPTH);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/lmps_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module lmps_back
    import lmps_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire        i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  wire        i_ready,
    output t_res       o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [16:0]      W_17    = 17'(WIDTH);
    localparam logic [16:0]      DEPTH17 = 17'(STORE_DEPTH);
    localparam logic [POS_W-1:0] LAST    = POS_W'(STORE_DEPTH - 1);

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [POS_W-1:0] r_cnt;
    logic [POS_W-1:0] n_cnt;
    logic [23:0]      r_fill;
    logic [23:0]      n_fill;
    logic [POS_W-1:0] r_rd_pos;
    logic [POS_W-1:0] n_rd_pos;
    logic             r_out_valid;
    t_res             r_out;

    logic [23:0]            r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;
    logic [23:0]            r_rd_data;
    logic                   r_rd_ok;

    logic [16:0]      w_prod;
    logic [16:0]      w_pos;
    logic             w_hit;
    logic             w_out_free;
    logic             w_we;
    logic [POS_W-1:0] w_waddr;
    logic [23:0]      w_wdata;
    logic             w_re;
    logic             w_load;
    t_res             w_res;

    assign w_prod     = 17'(i_cmd.crow) * W_17;
    assign w_pos      = w_prod + 17'(i_cmd.col);
    assign w_hit      = i_cmd.on_panel && (w_pos < DEPTH17);
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_fill   = r_fill;
        n_rd_pos = r_rd_pos;
        o_pop    = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_cnt;
        w_wdata  = r_fill;
        w_re     = 1'b0;
        w_load   = 1'b0;
        w_res    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty && w_out_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.mode)
                        MODE_WRITE: begin
                            w_load = 1'b1;
                            if (w_hit) begin
                                w_we    = 1'b1;
                                w_waddr = w_pos[POS_W-1:0];
                                w_wdata = {i_cmd.green, i_cmd.red, i_cmd.blue};
                                w_res   = {1'b1, w_pos[POS_W-1:0],
                                           i_cmd.green, i_cmd.red, i_cmd.blue};
                            end
                        end
                        MODE_FILL: begin
                            n_fill  = {i_cmd.green, i_cmd.red, i_cmd.blue};
                            n_cnt   = '0;
                            n_state = ST_FILL;
                        end
                        MODE_READ: begin
                            w_re     = 1'b1;
                            n_rd_pos = i_cmd.chain_pos;
                            n_state  = ST_READ;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    w_res   = {1'b1, r_rd_pos, r_rd_ok ? r_rd_data : 24'd0};
                    n_state = ST_IDLE;
                end
            end
            ST_FILL: begin
                w_we  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    w_res   = {1'b1, {POS_W{1'b0}}, r_fill};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill   <= n_fill;
        r_rd_pos <= n_rd_pos;
        if (w_load) begin
            r_out <= w_res;
        end
        if (w_re) begin
            r_rd_data <= r_mem[i_cmd.chain_pos];
            r_rd_ok   <= r_vld[i_cmd.chain_pos];
        end
    end

    // pixel store, green red blue
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

/* bench/tb_led_matrix_pixel_store_top.sv */
`timescale 1ns / 1ps

module tb_led_matrix_pixel_store_top;
    import lmps_pkg::*;

    localparam int PANEL_W = 16;
    localparam int PANEL_H = 16;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int N_PHASES        = 10;
    localparam int WORDS_PER_PHASE = 125;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  chain_pos;
    } t_led_item;

    typedef struct packed {
        t_led_item item;
        logic      typed;
        t_res      want;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [63:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;

    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [31:0] m_axis_tdata;   // mapped_pos, out_green, out_red, out_blue
    wire  [0:0]  m_axis_tuser;   // in_range
    wire  [31:0] prdata;
    wire         pready;

    // predictor state
    logic [23:0] led_store [STORE_DEPTH];
    t_cfg        led_cfg;
    t_res        led_results_q [$];
    t_res        led_front;

    int          err_count  = 0;
    int          burst_left = 0;
    logic [9:0]  rx_cyc     = '0;

    led_matrix_pixel_store_top #(
        .WIDTH  (PANEL_W),
        .HEIGHT (PANEL_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // chain position of a panel pixel, -1 when it falls off the panel
    function automatic int chain_pos_of(input int x, input int y);
        int col;
        int row;
        int crow;
        int span_c;
        int span_r;
        int p;
        if (x >= PANEL_W || y >= PANEL_H) return -1;
        col = x;
        row = y;
        span_c = PANEL_W;
        span_r = PANEL_H;
        case (led_cfg.rotation)
            ROT_90: begin
                col = PANEL_H - 1 - y;
                row = x;
                span_c = PANEL_H;
                span_r = PANEL_W;
            end
            ROT_180: begin
                col = PANEL_W - 1 - x;
                row = PANEL_H - 1 - y;
            end
            ROT_270: begin
                col = y;
                row = PANEL_W - 1 - x;
                span_c = PANEL_H;
                span_r = PANEL_W;
            end
            default: ;
        endcase
        if (led_cfg.mirror_x) col = span_c - 1 - col;
        if (led_cfg.mirror_y) row = span_r - 1 - row;
        if (col < 0 || col >= PANEL_W || row < 0 || row >= PANEL_H) return -1;
        crow = PANEL_H - 1 - row;
        if (led_cfg.serpentine && (crow % 2 == 1)) col = PANEL_W - 1 - col;
        p = crow * PANEL_W + col;
        return (p < STORE_DEPTH) ? p : -1;
    endfunction

    task automatic apply_led_item(input t_led_item it, output t_res res);
        int p;
        res = '0;
        case (it.mode)
            MODE_WRITE: begin
                p = chain_pos_of(int'(it.pos_x), int'(it.pos_y));
                if (p >= 0) begin
                    led_store[p] = {it.green, it.red, it.blue};
                    res.in_range = 1'b1;
                    res.mapped_pos = p[POS_W-1:0];
                    res.green = it.green;
                    res.red = it.red;
                    res.blue = it.blue;
                end
            end
            MODE_FILL: begin
                for (int i = 0; i < STORE_DEPTH; i++) led_store[i] = {it.green, it.red, it.blue};
                res.in_range = 1'b1;
                res.green = it.green;
                res.red = it.red;
                res.blue = it.blue;
            end
            MODE_READ: begin
                res.in_range = 1'b1;
                res.mapped_pos = it.chain_pos;
                {res.green, res.red, res.blue} = led_store[it.chain_pos];
            end
            default: ;
        endcase
    endtask

    function automatic t_dir_row mk_row(input logic [1:0] mode, input logic [15:0] x, y,
                                        input logic [7:0] r, g, b, cp,
                                        input logic typed, input t_res want);
        t_dir_row d;
        d.item = {mode, x, y, r, g, b, cp};
        d.typed = typed;
        d.want = want;
        return d;
    endfunction

    function automatic t_led_item rand_led_item();
        t_led_item it;
        int pick;
        it.pos_x = 16'($urandom);
        it.pos_y = 16'($urandom);
        it.red = 8'($urandom);
        it.green = 8'($urandom);
        it.blue = 8'($urandom);
        it.chain_pos = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.mode = MODE_WRITE;
            if ($urandom_range(0, 9) != 0) it.pos_x = 16'($urandom_range(0, PANEL_W - 1));
            if ($urandom_range(0, 9) != 0) it.pos_y = 16'($urandom_range(0, PANEL_H - 1));
        end else if (pick < 93) begin
            it.mode = MODE_READ;
        end else if (pick < 95) begin
            it.mode = MODE_FILL;
        end else begin
            it.mode = MODE_UNUSED;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic send_word(input t_led_item it, input logic typed, input t_res want);
        t_res pred;
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.mode;
        s_axis_tdata <= {it.chain_pos, it.blue, it.green, it.red, it.pos_y, it.pos_x};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_led_item(it, pred);
        led_results_q.push_back(typed ? want : pred);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ROTATION:   led_cfg.rotation = val[1:0];
            REG_SERPENTINE: led_cfg.serpentine = val[0];
            REG_MIRROR_X:   led_cfg.mirror_x = val[0];
            REG_MIRROR_Y:   led_cfg.mirror_y = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_results(input int tail);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (led_results_q.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // receiver stall pattern, stepped by rx_cyc[9:8]
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1'b1;
        case (rx_cyc[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_axis_tready <= (rx_cyc[1:0] == 2'd0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (led_results_q.size() == 0) begin
                report_mismatch("word with nothing expected", m_axis_tdata, '0);
            end else begin
                led_front = led_results_q.pop_front();
                if (m_axis_tuser[0] !== led_front.in_range)
                    report_mismatch("in_range", 32'(m_axis_tuser),
                                    32'(led_front.in_range));
                if (m_axis_tdata[7:0] !== led_front.mapped_pos)
                    report_mismatch("mapped_pos", 32'(m_axis_tdata[7:0]),
                                    32'(led_front.mapped_pos));
                if (m_axis_tdata[15:8] !== led_front.green)
                    report_mismatch("out_green", 32'(m_axis_tdata[15:8]),
                                    32'(led_front.green));
                if (m_axis_tdata[23:16] !== led_front.red)
                    report_mismatch("out_red", 32'(m_axis_tdata[23:16]),
                                    32'(led_front.red));
                if (m_axis_tdata[31:24] !== led_front.blue)
                    report_mismatch("out_blue", 32'(m_axis_tdata[31:24]),
                                    32'(led_front.blue));
            end
        end
    end

    initial begin : stimulus
        t_dir_row dir_tab [$];
        t_cfg     ph_cfg;

        foreach (led_store[i]) led_store[i] = '0;
        led_cfg = {ROT_270, 1'b1, 1'b0, 1'b0};

        dir_tab.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 8'd0, 1, {1'b1, 8'd0, 24'h0}));
        dir_tab.push_back(mk_row(MODE_READ, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'd255,
                                 1, {1'b1, 8'd255, 24'h0}));
        dir_tab.push_back(mk_row(MODE_WRITE, 16, 0, 8'hff, 8'hff, 8'hff, 0, 1, '0));
        dir_tab.push_back(mk_row(MODE_WRITE, 0, 16, 8'hff, 8'hff, 8'hff, 0, 1, '0));
        dir_tab.push_back(mk_row(MODE_WRITE, 16'hffff, 16'hffff, 8'h5a, 8'ha5, 8'h3c, 8'hff,
                                 1, '0));
        dir_tab.push_back(mk_row(MODE_WRITE, 16'h8000, 3, 8'h11, 8'h22, 8'h33, 0, 1, '0));
        dir_tab.push_back(mk_row(MODE_UNUSED, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff,
                                 1, '0));
        dir_tab.push_back(mk_row(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 1, '0));
        dir_tab.push_back(mk_row(MODE_WRITE, 0, 0, 8'hff, 8'h00, 8'h00, 0, 0, '0));
        dir_tab.push_back(mk_row(MODE_WRITE, 15, 15, 8'h00, 8'hff, 8'h00, 0, 0, '0));
        dir_tab.push_back(mk_row(MODE_WRITE, 15, 0, 8'h00, 8'h00, 8'hff, 0, 0, '0));
        dir_tab.push_back(mk_row(MODE_WRITE, 0, 15, 8'h01, 8'h80, 8'h7f, 0, 0, '0));
        dir_tab.push_back(mk_row(MODE_WRITE, 5, 10, 8'hc3, 8'h3c, 8'h96, 0, 0, '0));
        dir_tab.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 8'd0, 0, '0));
        dir_tab.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 8'd15, 0, '0));
        dir_tab.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 8'd240, 0, '0));
        dir_tab.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 8'd255, 0, '0));
        dir_tab.push_back(mk_row(MODE_FILL, 9, 4, 8'h12, 8'h34, 8'h56, 8'd7,
                                 1, {1'b1, 8'd0, 8'h34, 8'h12, 8'h56}));
        dir_tab.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 8'd255,
                                 1, {1'b1, 8'd255, 8'h34, 8'h12, 8'h56}));
        dir_tab.push_back(mk_row(MODE_WRITE, 7, 9, 8'hff, 8'hff, 8'hff, 0, 0, '0));
        dir_tab.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 8'd105, 0, '0));
        dir_tab.push_back(mk_row(MODE_FILL, 0, 0, 0, 0, 0, 0, 1, {1'b1, 8'd0, 24'h0}));
        dir_tab.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 8'd17, 1, {1'b1, 8'd17, 24'h0}));
        dir_tab.push_back(mk_row(MODE_FILL, 0, 0, 8'hff, 8'hff, 8'hff, 0,
                                 1, {1'b1, 8'd0, 24'hffffff}));
        dir_tab.push_back(mk_row(MODE_READ, 0, 0, 0, 0, 0, 8'd128,
                                 1, {1'b1, 8'd128, 24'hffffff}));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) send_word(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results(8);
            case (ph)
                0: ph_cfg = {ROT_0, 1'b0, 1'b0, 1'b0};
                1: ph_cfg = {ROT_270, 1'b1, 1'b1, 1'b1};
                2: ph_cfg = {ROT_90, 1'b1, 1'b0, 1'b0};
                3: ph_cfg = {ROT_180, 1'b0, 1'b1, 1'b0};
                4: ph_cfg = {ROT_90, 1'b0, 1'b1, 1'b1};
                5: ph_cfg = {ROT_180, 1'b1, 1'b0, 1'b1};
                6: ph_cfg = {ROT_270, 1'b0, 1'b0, 1'b1};
                7: ph_cfg = {ROT_0, 1'b1, 1'b1, 1'b1};
                default: ph_cfg = 5'($urandom);
            endcase
            write_reg(REG_ROTATION, {30'd0, ph_cfg.rotation});
            write_reg(REG_SERPENTINE, {31'd0, ph_cfg.serpentine});
            write_reg(REG_MIRROR_X, {31'd0, ph_cfg.mirror_x});
            write_reg(REG_MIRROR_Y, {31'd0, ph_cfg.mirror_y});
            for (int k = 0; k < WORDS_PER_PHASE; k++) send_word(rand_led_item(), 1'b0, '0);
        end

        drain_results(300);
        if (err_count == 0) begin
            $display("tb_led_matrix_pixel_store_top OK");
        end else begin
            $display("tb_led_matrix_pixel_store_top NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_led_matrix_pixel_store_top NOT OK");
        $finish;
    end

endmodule

/* sim.f */
hdl/lmps_pkg.sv
hdl/lmps_front.sv
hdl/lmps_fifo.sv
hdl/lmps_back.sv
hdl/led_matrix_pixel_store_top.sv
bench/tb_led_matrix_pixel_store_top.sv
